@@ design/arpc_pkg.sv @@
// Shared types, constants and helpers for the ARP cache table.
package arpc_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;

   localparam int OP_W      = 2;
   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int SLOT_W    = 5;
   localparam int EXP_W     = 6;
   localparam int AGE_W     = 8;
   localparam int TICK_W    = 32;
   localparam int LFSR_W    = 16;
   localparam int MOD_CNT_W = 5;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic [AGE_W-1:0]  AGE_LIMIT_RST = 8'd15;
   localparam logic [LFSR_W-1:0] LFSR_SEED     = 16'hACE1;
   localparam logic [EXP_W-1:0]  EXP_MAX       = 6'd63;

   typedef struct packed {
      logic              valid;
      logic [TICK_W-1:0] added;
      logic [IP_W-1:0]   ip;
   } tag_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic scan_step;
      logic mod_start;
      logic mod_step;
      logic repl_write;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic entry_stop;
      logic entry_last;
      logic mod_last;
   } sts_type;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[LFSR_W-1:1]};
   endfunction

endpackage

@@ design/arp_cache_table_core.sv @@
// Top level of the ARP cache table: IPv4-to-MAC cache with aging.
// Every lookup, insert and tick command scans the entry RAM one entry per cycle through its
//   read port; the strobe follows a full scan, or comes earlier on a hit or a free slot; a
//   full-table insert adds the two-step slot remainder and the replacement write.
// A command is taken only once the last has given its result; an unused opcode skips the scan.
// Reset: a clearing pass over every entry runs with busy high; csr writes still land.
// Results are a one-cycle strobe and cannot be stalled by the receiver.
module arp_cache_table_core import arpc_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [IP_W-1:0]    req_ip_address,
   input  logic [MAC_W-1:0]   req_mac_in,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [MAC_W-1:0]   rsp_mac_out,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic               rsp_replaced,
   output logic [EXP_W-1:0]   rsp_expired_count,
   input  logic               csr_wr_en,
   input  logic [AGE_W-1:0]   csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   arpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   arpc_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_ip_address    (req_ip_address),
      .req_mac_in        (req_mac_in),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_hit           (rsp_hit),
      .rsp_mac_out       (rsp_mac_out),
      .rsp_slot          (rsp_slot),
      .rsp_replaced      (rsp_replaced),
      .rsp_expired_count (rsp_expired_count)
   );

endmodule

@@ design/arpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/arpc_ctrl.sv @@
// Controller state machine for the ARP cache table.
module arpc_ctrl import arpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] req_operation,
   input  sts_type         sts,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               if (req_operation == OP_LOOKUP || req_operation == OP_INSERT ||
                   req_operation == OP_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.entry_stop) begin
               state_in = ST_DONE;
            end else if (sts.entry_last) begin
               if (op_ff == OP_INSERT) begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.repl_write = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

@@ design/arpc_dpath.sv @@
// Datapath for the ARP cache table: entry stores, scan, aging and replacement.
module arpc_dpath import arpc_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [IP_W-1:0]    req_ip_address,
   input  logic [MAC_W-1:0]   req_mac_in,
   input  logic               csr_wr_en,
   input  logic [AGE_W-1:0]   csr_wr_data,
   output logic               rsp_hit,
   output logic [MAC_W-1:0]   rsp_mac_out,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic               rsp_replaced,
   output logic [EXP_W-1:0]   rsp_expired_count
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int TAG_W   = $bits(tag_type);
   localparam int RCP_SH  = 32;
   localparam int PROD_W  = LFSR_W + RCP_SH;
   localparam logic [CNT_W-1:0]   CNT_TOP   = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [LFSR_W-1:0]  MOD_DIV   = LFSR_W'(TABLE_ENTRIES);
   localparam logic [RCP_SH-1:0]  RCP_MUL   =
      RCP_SH'(((longint'(1) << RCP_SH) + longint'(TABLE_ENTRIES) - longint'(1)) /
              longint'(TABLE_ENTRIES));

   logic [AGE_W-1:0]     age_limit_ff, age_limit_in;
   logic [TICK_W-1:0]    now_ff, now_in;
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [IP_W-1:0]      key_ip_ff, key_ip_in;
   logic [MAC_W-1:0]     key_mac_ff, key_mac_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [LFSR_W-1:0]    div_ff, div_in;
   logic [LFSR_W-1:0]    quot_ff, quot_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic                 hit_ff, hit_in;
   logic [MAC_W-1:0]     mac_out_ff, mac_out_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 replaced_ff, replaced_in;
   logic [EXP_W-1:0]     expired_ff, expired_in;

   tag_type              tag_rd, tag_wr, tag_new;
   logic [TAG_W-1:0]     tag_rd_bits;
   logic [MAC_W-1:0]     mac_rd;
   logic                 tag_we, mac_we;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic                 issue;
   logic [TICK_W-1:0]    age;
   logic                 hit_now, free_now, expire_now;
   logic [PROD_W-1:0]    quot_prod;
   logic [LFSR_W-1:0]    rem_full;
   logic [LFSR_W-1:0]    lfsr_step;

   arpc_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_ENTRIES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_addr),
      .wr_data (tag_wr),
      .rd_addr (rd_addr),
      .rd_data (tag_rd_bits)
   );

   arpc_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_we),
      .wr_addr (wr_addr),
      .wr_data (key_mac_ff),
      .rd_addr (rd_addr),
      .rd_data (mac_rd)
   );

   assign tag_rd     = tag_rd_bits;
   assign issue      = cmd.scan_step && (cnt_ff < CNT_TOP);
   assign rd_addr    = issue ? cnt_ff[IDX_W-1:0] : '0;
   assign age        = now_ff - tag_rd.added;
   assign hit_now    = chk_vld_ff && (op_ff == OP_LOOKUP) && tag_rd.valid &&
                       (tag_rd.ip == key_ip_ff);
   assign free_now   = chk_vld_ff && (op_ff == OP_INSERT) && !tag_rd.valid;
   assign expire_now = chk_vld_ff && (op_ff == OP_TICK) && tag_rd.valid &&
                       (age > TICK_W'(age_limit_ff));
   assign quot_prod  = PROD_W'(div_ff) * PROD_W'(RCP_MUL);
   assign rem_full   = div_ff - quot_ff * MOD_DIV;
   assign lfsr_step  = lfsr_next(lfsr_ff);

   assign sts.clear_last = (cnt_ff == CNT_LAST);
   assign sts.entry_stop = hit_now || free_now;
   assign sts.entry_last = chk_vld_ff && (chk_idx_ff == IDX_LAST);
   assign sts.mod_last   = (mod_cnt_ff == MOD_CNT_W'(1));

   always_comb begin
      tag_new.valid = 1'b1;
      tag_new.added = now_ff;
      tag_new.ip    = key_ip_ff;
      tag_we        = 1'b0;
      mac_we        = 1'b0;
      wr_addr       = chk_idx_ff;
      tag_wr        = tag_new;
      if (cmd.clear_step) begin
         tag_we  = 1'b1;
         wr_addr = cnt_ff[IDX_W-1:0];
         tag_wr  = '0;
      end else if (cmd.repl_write) begin
         tag_we  = 1'b1;
         mac_we  = 1'b1;
         wr_addr = rem_ff;
      end else if (cmd.scan_step && free_now) begin
         tag_we = 1'b1;
         mac_we = 1'b1;
      end else if (cmd.scan_step && expire_now) begin
         tag_we       = 1'b1;
         tag_wr       = tag_rd;
         tag_wr.valid = 1'b0;
      end
   end

   always_comb begin
      age_limit_in = csr_wr_en ? csr_wr_data : age_limit_ff;
      now_in       = now_ff;
      lfsr_in      = lfsr_ff;
      op_in        = op_ff;
      key_ip_in    = key_ip_ff;
      key_mac_in   = key_mac_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = issue;
      chk_idx_in   = chk_idx_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      hit_in       = hit_ff;
      mac_out_in   = mac_out_ff;
      slot_in      = slot_ff;
      replaced_in  = replaced_ff;
      expired_in   = expired_ff;

      if (cmd.load) begin
         op_in       = req_operation;
         key_ip_in   = req_ip_address;
         key_mac_in  = req_mac_in;
         cnt_in      = '0;
         hit_in      = 1'b0;
         mac_out_in  = '0;
         slot_in     = '0;
         replaced_in = 1'b0;
         expired_in  = '0;
         if (req_operation == OP_TICK) begin
            now_in = now_ff + TICK_W'(1);
         end
      end

      if (cmd.clear_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (issue) begin
         cnt_in     = cnt_ff + CNT_W'(1);
         chk_idx_in = cnt_ff[IDX_W-1:0];
      end

      if (cmd.scan_step) begin
         if (hit_now) begin
            hit_in     = 1'b1;
            mac_out_in = mac_rd;
            slot_in    = SLOT_W'(chk_idx_ff);
         end
         if (free_now) begin
            slot_in = SLOT_W'(chk_idx_ff);
         end
         if (expire_now && expired_ff != EXP_MAX) begin
            expired_in = expired_ff + EXP_W'(1);
         end
      end

      if (cmd.mod_start) begin
         lfsr_in    = lfsr_step;
         div_in     = lfsr_step;
         rem_in     = '0;
         mod_cnt_in = MOD_CNT_W'(2);
      end

      if (cmd.mod_step) begin
         if (mod_cnt_ff == MOD_CNT_W'(2)) begin
            quot_in = quot_prod[PROD_W-1:RCP_SH];
         end else begin
            rem_in = rem_full[IDX_W-1:0];
         end
         mod_cnt_in = mod_cnt_ff - MOD_CNT_W'(1);
      end

      if (cmd.repl_write) begin
         replaced_in = 1'b1;
         slot_in     = SLOT_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RST;
         now_ff       <= '0;
         lfsr_ff      <= LFSR_SEED;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         mod_cnt_ff   <= '0;
      end else begin
         age_limit_ff <= age_limit_in;
         now_ff       <= now_in;
         lfsr_ff      <= lfsr_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         mod_cnt_ff   <= mod_cnt_in;
      end
      op_ff       <= op_in;
      key_ip_ff   <= key_ip_in;
      key_mac_ff  <= key_mac_in;
      chk_idx_ff  <= chk_idx_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      hit_ff      <= hit_in;
      mac_out_ff  <= mac_out_in;
      slot_ff     <= slot_in;
      replaced_ff <= replaced_in;
      expired_ff  <= expired_in;
   end

   assign rsp_hit           = hit_ff;
   assign rsp_mac_out       = mac_out_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_replaced      = replaced_ff;
   assign rsp_expired_count = expired_ff;

endmodule

@@ design/arpc_checker.sv @@
// Port-level checker for the ARP cache table core, with its bind.
module arpc_checker import arpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               rsp_valid,
   input  logic               rsp_hit,
   input  logic [MAC_W-1:0]   rsp_mac_out,
   input  logic               rsp_replaced,
   input  logic [EXP_W-1:0]   rsp_expired_count
);

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a command transfer");

   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_miss_zero_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_mac_out == '0)
      else $error("nonzero MAC on a result without hit");

   a_result_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit || rsp_replaced) |->
         rsp_expired_count == '0 && !(rsp_hit && rsp_replaced))
      else $error("result mixes lookup, insert and tick fields");

endmodule

bind arp_cache_table_core arpc_checker u_arpc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_mac_out       (rsp_mac_out),
   .rsp_replaced      (rsp_replaced),
   .rsp_expired_count (rsp_expired_count)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the ARP cache table: directed rows, then random traffic episodes.
`timescale 1ns / 100ps

module testbench;
   import arpc_pkg::*;

   localparam int TABLE_N    = TABLE_ENTRIES_DEF;
   localparam int RAND_ITEMS = 1600;
   localparam int POOL_N     = 12;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic              hit;
      logic [MAC_W-1:0]  mac_out;
      logic [SLOT_W-1:0] slot;
      logic              replaced;
      logic [EXP_W-1:0]  expired;
   } arp_rsp_type;

   typedef struct packed {
      logic              is_csr;
      logic              typed;
      logic [OP_W-1:0]   op;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [AGE_W-1:0]  csr_val;
      arp_rsp_type       want;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_operation = '0;
   logic [IP_W-1:0]    req_ip_address = '0;
   logic [MAC_W-1:0]   req_mac_in = '0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [MAC_W-1:0]   rsp_mac_out;
   logic [SLOT_W-1:0]  rsp_slot;
   logic               rsp_replaced;
   logic [EXP_W-1:0]   rsp_expired_count;
   logic               csr_wr_en = 1'b0;
   logic [AGE_W-1:0]   csr_wr_data = '0;

   logic [IP_W-1:0]    tbl_ip    [TABLE_N];
   logic [MAC_W-1:0]   tbl_mac   [TABLE_N];
   logic               tbl_valid [TABLE_N];
   logic [TICK_W-1:0]  tbl_added [TABLE_N];
   logic [TICK_W-1:0]  tick_now;
   logic [LFSR_W-1:0]  repl_lfsr;
   logic [AGE_W-1:0]   cur_age_limit;

   logic [IP_W-1:0]    ip_pool [POOL_N];
   arp_rsp_type        awaited_rsp [$];
   dir_row_type        dir_rows [$];

   int mismatches   = 0;
   int items_sent   = 0;
   int rand_items   = 0;
   int age_settings = 0;
   int hit_cnt      = 0;
   int evict_cnt    = 0;
   int aged_cnt     = 0;
   int aged_max     = 0;

   arp_cache_table_core #(
      .TABLE_ENTRIES(TABLE_N)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_ip_address   (req_ip_address),
      .req_mac_in       (req_mac_in),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_mac_out      (rsp_mac_out),
      .rsp_slot         (rsp_slot),
      .rsp_replaced     (rsp_replaced),
      .rsp_expired_count(rsp_expired_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [LFSR_W-1:0] replace_shift(input logic [LFSR_W-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[LFSR_W-1:1]};
   endfunction

   function automatic arp_rsp_type arp_table_step(input logic [OP_W-1:0] op,
                                                  input logic [IP_W-1:0] ip,
                                                  input logic [MAC_W-1:0] mac);
      arp_rsp_type r;
      int idx;
      int n_exp;
      logic [TICK_W-1:0] age;
      r = '0;
      idx = -1;
      n_exp = 0;
      case (op)
         OP_LOOKUP: begin
            for (int i = 0; i < TABLE_N; i++)
               if (idx < 0 && tbl_valid[i] && tbl_ip[i] == ip) idx = i;
            if (idx >= 0) begin
               r.hit = 1'b1;
               r.mac_out = tbl_mac[idx];
               r.slot = SLOT_W'(idx);
               hit_cnt++;
            end
         end
         OP_INSERT: begin
            for (int i = 0; i < TABLE_N; i++)
               if (idx < 0 && !tbl_valid[i]) idx = i;
            if (idx < 0) begin
               repl_lfsr = replace_shift(repl_lfsr);
               idx = int'(repl_lfsr) % TABLE_N;
               r.replaced = 1'b1;
               evict_cnt++;
            end
            tbl_ip[idx] = ip;
            tbl_mac[idx] = mac;
            tbl_added[idx] = tick_now;
            tbl_valid[idx] = 1'b1;
            r.slot = SLOT_W'(idx);
         end
         OP_TICK: begin
            tick_now = tick_now + 1;
            for (int i = 0; i < TABLE_N; i++) begin
               age = tick_now - tbl_added[i];
               if (tbl_valid[i] && age > TICK_W'(cur_age_limit)) begin
                  tbl_valid[i] = 1'b0;
                  n_exp++;
               end
            end
            r.expired = (n_exp > 63) ? EXP_MAX : EXP_W'(n_exp);
            aged_cnt += n_exp;
            if (n_exp > aged_max) aged_max = n_exp;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic dir_row_type item_row(input logic [OP_W-1:0] op,
                                            input logic [IP_W-1:0] ip,
                                            input logic [MAC_W-1:0] mac);
      dir_row_type d;
      d = '0;
      d.op = op;
      d.ip = ip;
      d.mac = mac;
      return d;
   endfunction

   function automatic dir_row_type fixed_row(input logic [OP_W-1:0] op,
                                             input logic [IP_W-1:0] ip,
                                             input logic [MAC_W-1:0] mac, input logic hit,
                                             input logic [MAC_W-1:0] mac_out,
                                             input logic [SLOT_W-1:0] slot);
      dir_row_type d;
      d = item_row(op, ip, mac);
      d.typed = 1'b1;
      d.want.hit = hit;
      d.want.mac_out = mac_out;
      d.want.slot = slot;
      return d;
   endfunction

   function automatic dir_row_type csr_row(input logic [AGE_W-1:0] v);
      dir_row_type d;
      d = '0;
      d.is_csr = 1'b1;
      d.csr_val = v;
      return d;
   endfunction

   function automatic logic [IP_W-1:0] pick_ip();
      if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, POOL_N - 1)];
      return $urandom();
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac, input logic use_fixed,
                            input arp_rsp_type fixed);
      arp_rsp_type p;
      start <= 1'b1;
      req_operation <= op;
      req_ip_address <= ip;
      req_mac_in <= mac;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      p = arp_table_step(op, ip, mac);
      awaited_rsp.push_back(use_fixed ? fixed : p);
      items_sent++;
   endtask

   task automatic send_rand(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip);
      int pct;
      send_item(op, ip, rand_mac(), 1'b0, '0);
      rand_items++;
      pct = (rand_items < RAND_ITEMS / 3) ? 11 : (rand_items < 2 * RAND_ITEMS / 3) ? 72 : 0;
      if ($urandom_range(0, 99) < pct) hold_off($urandom_range(1, 60));
   endtask

   task automatic wait_idle();
      hold_off(1);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_age_limit(input logic [AGE_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      cur_age_limit = v;
      age_settings++;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      arp_rsp_type want;
      if (!reset && rsp_valid == 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $error("result transfer with no command outstanding");
            mismatches++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               mismatches++;
            end
            if (rsp_mac_out !== want.mac_out) begin
               $error("mac_out: expected %h, got %h", want.mac_out, rsp_mac_out);
               mismatches++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
               mismatches++;
            end
            if (rsp_replaced !== want.replaced) begin
               $error("replaced: expected %0d, got %0d", want.replaced, rsp_replaced);
               mismatches++;
            end
            if (rsp_expired_count !== want.expired) begin
               $error("expired_count: expected %0d, got %0d", want.expired, rsp_expired_count);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [AGE_W-1:0] age_sel;
      int ep;
      int r;
      logic [OP_W-1:0] op;
      for (int i = 0; i < TABLE_N; i++) begin
         tbl_ip[i] = '0;
         tbl_mac[i] = '0;
         tbl_valid[i] = 1'b0;
         tbl_added[i] = '0;
      end
      tick_now = '0;
      repl_lfsr = LFSR_SEED;
      cur_age_limit = AGE_LIMIT_RST;

      dir_rows.push_back(fixed_row(OP_LOOKUP, '0, '0, 1'b0, '0, '0));
      dir_rows.push_back(fixed_row(OP_LOOKUP, '1, '1, 1'b0, '0, '0));
      dir_rows.push_back(fixed_row(OP_UNUSED, '1, '1, 1'b0, '0, '0));
      dir_rows.push_back(fixed_row(OP_TICK, '1, '1, 1'b0, '0, '0));
      dir_rows.push_back(fixed_row(OP_INSERT, '0, '0, 1'b0, '0, 5'd0));
      dir_rows.push_back(fixed_row(OP_INSERT, '1, '1, 1'b0, '0, 5'd1));
      dir_rows.push_back(fixed_row(OP_LOOKUP, '1, '0, 1'b1, '1, 5'd1));
      dir_rows.push_back(fixed_row(OP_LOOKUP, '0, '1, 1'b1, '0, 5'd0));
      dir_rows.push_back(fixed_row(OP_INSERT, '0, 48'h5A5A_A5A5_0F0F, 1'b0, '0, 5'd2));
      dir_rows.push_back(fixed_row(OP_LOOKUP, '0, '0, 1'b1, '0, 5'd0));
      dir_rows.push_back(fixed_row(OP_LOOKUP, 32'd1, '0, 1'b0, '0, '0));
      dir_rows.push_back(fixed_row(OP_UNUSED, '0, '0, 1'b0, '0, '0));
      dir_rows.push_back(item_row(OP_INSERT, 32'h8000_0001, 48'h8000_0000_0001));
      dir_rows.push_back(csr_row('0));
      dir_rows.push_back(item_row(OP_TICK, '0, '0));
      dir_rows.push_back(item_row(OP_LOOKUP, '1, '0));
      dir_rows.push_back(csr_row('1));
      dir_rows.push_back(item_row(OP_INSERT, 32'hC0A8_0001, 48'h001B_213C_4D5E));
      dir_rows.push_back(item_row(OP_TICK, '0, '0));
      dir_rows.push_back(item_row(OP_LOOKUP, 32'hC0A8_0001, '0));
      dir_rows.push_back(csr_row(AGE_LIMIT_RST));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_csr) begin
            wait_idle();
            write_age_limit(dir_rows[k].csr_val);
         end else begin
            send_item(dir_rows[k].op, dir_rows[k].ip, dir_rows[k].mac, dir_rows[k].typed,
                      dir_rows[k].want);
         end
      end

      ep = 0;
      while (rand_items < RAND_ITEMS) begin
         wait_idle();
         case (ep % 6)
            0:       age_sel = '0;
            1:       age_sel = '1;
            2:       age_sel = 8'd1;
            3:       age_sel = AGE_LIMIT_RST;
            4:       age_sel = AGE_W'($urandom_range(0, 7));
            default: age_sel = AGE_W'($urandom_range(0, 255));
         endcase
         write_age_limit(age_sel);
         foreach (ip_pool[i]) ip_pool[i] = $urandom();
         case ($urandom_range(0, 3))
            0: ip_pool[0] = '0;
            1: ip_pool[0] = '1;
            default: ;
         endcase
         case ($urandom_range(0, 7))
            0, 1, 2: begin
               repeat (60) begin
                  r = $urandom_range(0, 99);
                  op = (r < 35) ? OP_INSERT : (r < 80) ? OP_LOOKUP :
                       (r < 95) ? OP_TICK : OP_UNUSED;
                  send_rand(op, pick_ip());
               end
            end
            3, 4, 5: begin
               repeat ($urandom_range(34, 40)) send_rand(OP_INSERT, pick_ip());
               repeat (8) send_rand(OP_LOOKUP, pick_ip());
               repeat ($urandom_range(1, 20)) send_rand(OP_TICK, pick_ip());
               repeat (6) send_rand(OP_LOOKUP, pick_ip());
            end
            6: begin
               repeat (50)
                  send_rand(($urandom_range(0, 99) < 80) ? OP_LOOKUP : OP_INSERT, pick_ip());
            end
            default: begin
               repeat (20) send_rand(OP_W'($urandom_range(0, 3)), $urandom());
            end
         endcase
         ep++;
      end

      hold_off(1);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d commands over %0d age-limit settings: %0d lookup hits, %0d evictions",
               items_sent, age_settings, hit_cnt, evict_cnt);
      $display("Aged out %0d entries in total, up to %0d on a single tick", aged_cnt, aged_max);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ arp_cache_table_core.f @@
design/arpc_pkg.sv
design/arpc_ram.sv
design/arpc_ctrl.sv
design/arpc_dpath.sv
design/arp_cache_table_core.sv
design/arpc_checker.sv
sim/testbench.sv
